// File: hdl/relocation_patch_unit_top_defines.svh
// Assertion macros for the relocation patch unit.
// Included by the top level; the macros expect i_clk and i_rst_n in scope.
`ifndef RELOCATION_PATCH_UNIT_TOP_DEFINES_SVH
`define RELOCATION_PATCH_UNIT_TOP_DEFINES_SVH

// A condition that must hold at every clock edge outside reset.
`define RPU_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("rpu assertion failed");

// A condition that, when it holds, forces another one in the next cycle.
`define RPU_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rpu assertion failed");

`endif

// File: hdl/rpu_pkg.sv
// Package for the relocation patch unit: field widths, codes, stage and result types.
// No dependencies; used by relocation_patch_unit_top.
package rpu_pkg;

    localparam int unsigned ADDR_W = 32;

    localparam logic       OP_APPLY = 1'b0;
    localparam logic       OP_SLOT  = 1'b1;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_TARGET  = 3'd1;
    localparam logic [2:0] ST_SLOT    = 3'd2;
    localparam logic [2:0] ST_KIND    = 3'd3;
    localparam logic [2:0] ST_EARLIER = 3'd4;

    localparam logic [2:0] KIND_ABS32 = 3'd0;
    localparam logic [2:0] KIND_CALL  = 3'd1;
    localparam logic [2:0] KIND_LIT   = 3'd2;
    localparam logic [2:0] KIND_API   = 3'd3;

    localparam logic [7:0] TGT_CODE   = 8'd0;
    localparam logic [7:0] TGT_RODATA = 8'd1;
    localparam logic [7:0] TGT_DATA   = 8'd2;
    localparam logic [7:0] TGT_BSS    = 8'd3;
    localparam logic [7:0] TGT_API    = 8'h10;

    localparam logic [2:0] CFG_LOAD_ADDR    = 3'd0;
    localparam logic [2:0] CFG_CODE_BYTES   = 3'd1;
    localparam logic [2:0] CFG_RODATA_BYTES = 3'd2;
    localparam logic [2:0] CFG_DATA_BYTES   = 3'd3;
    localparam logic [2:0] CFG_API_ENTRIES  = 3'd4;

    typedef struct packed {
        logic                apply;
        logic                last;
        logic [2:0]          status;
        logic                use_api;
        logic                is_call;
        logic [ADDR_W-1:0]   addr;
        logic [ADDR_W-1:0]   addr_p3;
        logic [ADDR_W-1:0]   sect_base;
        logic [ADDR_W-1:0]   addend_sx;
        logic [7:0]          old_top;
    } t_stage;

    typedef struct packed {
        logic                run_done;
        logic [2:0]          status;
        logic [ADDR_W-1:0]   patch_word;
        logic [ADDR_W-1:0]   patch_address;
        logic                write_enable;
    } t_result;

endpackage

// File: hdl/relocation_patch_unit_top.sv
// Relocation patch unit: resolves relocation entries into patch address and word.
// Depends on rpu_pkg and relocation_patch_unit_top_defines.svh.
//
// Usage: requests enter on the s_axis channel, one per accepted beat. tuser selects
// apply (0) or API table slot write (1); tlast marks the last entry of a table.
// Each request gives exactly one result on m_axis, in order; slot writes give an
// all-zero result. Configuration registers are written over the cfg port; the user
// must do so only while no request is in flight; the block does not enforce it.
// A request passes through stage 1 and then the output register before m_axis: the
// step into stage 1 resolves section bases and reads the API table memory (one
// synchronous port), the step into the output register adds the addend and forms
// the call offset. Throughput is one request per cycle while m_axis is not stalled.
// Reset clears the configuration registers, the pipeline and the sticky error flag;
// the API table is not cleared and must be loaded before it is referenced.
// When the receiver stalls, the result waits in the output register and the
// pipeline fills; s_axis_tready falls once both stages are full.
`include "relocation_patch_unit_top_defines.svh"

module relocation_patch_unit_top
    import rpu_pkg::*;
#(
    parameter int unsigned API_SLOTS = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // patch_offset[23:0], target_id[31:24], addend[47:32], reloc_kind[50:48],
    // old_word[82:51], slot_index[88:83], slot_value[120:89], zero fill above
    input  logic [127:0] s_axis_tdata,
    // operation
    input  logic         s_axis_tuser,
    // last_entry
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // write_enable[0], patch_address[32:1], patch_word[64:33], status[67:65],
    // run_done[68], zero fill above
    output logic [71:0]  m_axis_tdata
);

    localparam int unsigned IDX_W = (API_SLOTS > 1) ? $clog2(API_SLOTS) : 1;
    localparam logic [7:0]  SLOTS8 = 8'(API_SLOTS);

    logic [31:0] r_load_addr;
    logic [23:0] r_code_bytes;
    logic [23:0] r_rodata_bytes;
    logic [23:0] r_data_bytes;
    logic [6:0]  r_api_entries;

    logic [31:0] mem [API_SLOTS];
    logic [31:0] r_rd_data;

    logic        r_s1_vld;
    t_stage      r_s1;
    logic        r_out_vld;
    t_result     r_out;
    logic        r_run_failed;
    logic        n_run_failed;

    logic        in_acc;
    logic        s1_adv;

    logic [23:0] f_offset;
    logic [7:0]  f_target;
    logic [15:0] f_addend;
    logic [2:0]  f_kind;
    logic [31:0] f_old_word;
    logic [5:0]  f_slot;
    logic [31:0] f_slot_value;

    logic [7:0]  api_idx;
    logic        api_ok;
    logic [7:0]  slot8;
    logic        slot_ok;
    logic [25:0] size_sum;
    t_stage      s0;

    logic [31:0] base;
    logic [31:0] value;
    logic [31:0] rel;
    logic [31:0] word;
    t_result     res;

    assign f_offset     = s_axis_tdata[23:0];
    assign f_target     = s_axis_tdata[31:24];
    assign f_addend     = s_axis_tdata[47:32];
    assign f_kind       = s_axis_tdata[50:48];
    assign f_old_word   = s_axis_tdata[82:51];
    assign f_slot       = s_axis_tdata[88:83];
    assign f_slot_value = s_axis_tdata[120:89];

    assign s1_adv        = r_s1_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_s1_vld || s1_adv;
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    assign api_idx = f_target - TGT_API;
    assign api_ok  = (f_target >= TGT_API) && (api_idx < {1'b0, r_api_entries})
                     && (api_idx < SLOTS8);
    assign slot8   = {2'b00, f_slot};
    assign slot_ok = slot8 < SLOTS8;

    always_comb begin
        size_sum = 26'd0;
        case (f_target)
            TGT_RODATA: begin
                size_sum = {2'b00, r_code_bytes};
            end
            TGT_DATA: begin
                size_sum = {2'b00, r_code_bytes} + {2'b00, r_rodata_bytes};
            end
            TGT_BSS: begin
                size_sum = {2'b00, r_code_bytes} + {2'b00, r_rodata_bytes}
                           + {2'b00, r_data_bytes};
            end
            default: begin
                size_sum = 26'd0;
            end
        endcase

        s0.apply     = (s_axis_tuser == OP_APPLY);
        s0.last      = s_axis_tlast;
        s0.use_api   = (f_target >= TGT_API);
        s0.is_call   = (f_kind == KIND_CALL);
        s0.addr      = r_load_addr + {8'd0, f_offset};
        s0.addr_p3   = r_load_addr + {8'd0, f_offset} + 32'd3;
        s0.sect_base = r_load_addr + {6'd0, size_sum};
        s0.addend_sx = {{16{f_addend[15]}}, f_addend};
        s0.old_top   = f_old_word[31:24];
        if (f_target <= TGT_BSS) begin
            s0.status = ST_OK;
        end else if (f_target < TGT_API) begin
            s0.status = ST_TARGET;
        end else if (!api_ok) begin
            s0.status = ST_SLOT;
        end else begin
            s0.status = ST_OK;
        end
        if (s0.status == ST_OK && f_kind != KIND_ABS32 && f_kind != KIND_CALL
            && f_kind != KIND_LIT && f_kind != KIND_API) begin
            s0.status = ST_KIND;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && s_axis_tuser == OP_SLOT && slot_ok) begin
            mem[slot8[IDX_W-1:0]] <= f_slot_value;
        end
        if (in_acc && s_axis_tuser == OP_APPLY && api_ok) begin
            r_rd_data <= mem[api_idx[IDX_W-1:0]];
        end
    end

    always_comb begin
        base  = r_s1.use_api ? r_rd_data : r_s1.sect_base;
        value = base + r_s1.addend_sx;
        rel   = value - r_s1.addr_p3;
        word  = r_s1.is_call ? {r_s1.old_top, rel[25:2]} : value;

        res          = '0;
        n_run_failed = r_run_failed;
        if (r_s1.apply) begin
            res.patch_address = r_s1.addr;
            if (r_run_failed) begin
                res.status   = ST_EARLIER;
                n_run_failed = !r_s1.last;
            end else if (r_s1.status != ST_OK) begin
                res.status   = r_s1.status;
                n_run_failed = !r_s1.last;
            end else begin
                res.write_enable = 1'b1;
                res.patch_word   = word;
                res.status       = ST_OK;
                res.run_done     = r_s1.last;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_addr    <= '0;
            r_code_bytes   <= '0;
            r_rodata_bytes <= '0;
            r_data_bytes   <= '0;
            r_api_entries  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_LOAD_ADDR:    r_load_addr    <= i_cfg_data;
                CFG_CODE_BYTES:   r_code_bytes   <= i_cfg_data[23:0];
                CFG_RODATA_BYTES: r_rodata_bytes <= i_cfg_data[23:0];
                CFG_DATA_BYTES:   r_data_bytes   <= i_cfg_data[23:0];
                CFG_API_ENTRIES:  r_api_entries  <= i_cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld     <= 1'b0;
            r_out_vld    <= 1'b0;
            r_run_failed <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld    <= 1'b1;
                r_run_failed <= n_run_failed;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1 <= s0;
        end
        if (s1_adv) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {3'b000, r_out};

    `RPU_ASSERT_ALWAYS(a_err_no_write,
        !r_out_vld || r_out.status == ST_OK || !r_out.write_enable)
    `RPU_ASSERT_ALWAYS(a_done_is_ok,
        !r_out_vld || !r_out.run_done || (r_out.write_enable && r_out.status == ST_OK))
    `RPU_ASSERT_NEXT(a_sticky_holds,
        s1_adv && r_s1.apply && r_run_failed && !r_s1.last, r_run_failed)
    `RPU_ASSERT_NEXT(a_last_clears,
        s1_adv && r_s1.apply && r_s1.last, !r_run_failed)

endmodule
